### sv/kufe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kufe_pkg;

  // Size of the vertex set, the vertex index width derived from it, and data widths
  localparam int NUM_VERTICES = 65536;
  localparam int VTX_W        = $clog2(NUM_VERTICES);
  localparam int NODE_W       = 16;
  localparam int WGT_W        = 8;
  localparam int CNT_W        = 16;

  // Input operation codes
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK
  } kufe_state_e;

  typedef logic [VTX_W-1:0] vtx_t;

endpackage

`default_nettype wire

### sv/kufe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kufe_ram #(
  parameter int DEPTH = 65536,
  parameter int DW    = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the new data when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/kruskal_union_find_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                          Direction
// command   start, busy (out), op_i, node_a_i, node_b_i,     in
//           edge_weight_i
// result    done_o, joined_o, out_node_a_o, out_node_b_o,    out
//           out_weight_o, tree_edges_o
//
// Edge transaction: each root walk is a run of lookups, followed by
// compression writes along the path when the start vertex is not the root,
// then a link step; the pace is set by the single read port of the parent
// memory. The result strobe follows in the cycle after the link step.
// After reset and after a restart transaction the parent memory is rewritten
// one entry a cycle; busy is high throughout. The
// receiver cannot stall: done_o is high for exactly one cycle per transaction.

module kruskal_union_find_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         op_i,
  input  wire logic [kufe_pkg::NODE_W-1:0]  node_a_i,
  input  wire logic [kufe_pkg::NODE_W-1:0]  node_b_i,
  input  wire logic [kufe_pkg::WGT_W-1:0]   edge_weight_i,
  output logic                              done_o,
  output logic                              joined_o,
  output logic [kufe_pkg::NODE_W-1:0]       out_node_a_o,
  output logic [kufe_pkg::NODE_W-1:0]       out_node_b_o,
  output logic [kufe_pkg::WGT_W-1:0]        out_weight_o,
  output logic [kufe_pkg::CNT_W-1:0]        tree_edges_o
);

  import kufe_pkg::*;

  kufe_state_e state_q, state_d;

  logic [NODE_W-1:0] a_q, a_d, b_q, b_d;
  logic [WGT_W-1:0]  w_q, w_d;
  vtx_t              cur_q, cur_d, root_q, root_d, ra_q, ra_d, rb_q, rb_d;
  vtx_t              clr_idx_q, clr_idx_d;
  logic              phase_q, phase_d;
  logic              report_q, report_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              done_q, done_d, joined_q, joined_d;
  logic [NODE_W-1:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [WGT_W-1:0]  out_w_q, out_w_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  // Memory port signals
  logic  ram_we;
  vtx_t  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // Decode helpers
  logic  accept, in_rng, root_hit, comp_end, clr_last;
  vtx_t  va_in, va, vb, start_v;

  assign accept   = start && !busy;
  assign va_in    = VTX_W'(node_a_i);
  assign in_rng   = (32'(node_a_i) < NUM_VERTICES) && (32'(node_b_i) < NUM_VERTICES);
  assign va       = VTX_W'(a_q);
  assign vb       = VTX_W'(b_q);
  assign start_v  = phase_q ? vb : va;
  assign root_hit = (ram_rdata == cur_q);
  assign comp_end = (ram_rdata == root_q);
  assign clr_last = (clr_idx_q == VTX_W'(NUM_VERTICES - 1));

  kufe_ram #(
    .DEPTH (NUM_VERTICES),
    .DW    (VTX_W)
  ) u_parent (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_RESTART) state_d = ST_CLEAR;
          else if (in_rng)        state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (root_hit) begin
          if (start_v != cur_q) state_d = ST_COMP;
          else if (phase_q)     state_d = ST_LINK;
        end
      end
      ST_COMP: begin
        if (comp_end && phase_q) state_d = ST_LINK;
        else if (comp_end)       state_d = ST_FIND;
      end
      ST_LINK: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    cur_d     = cur_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    clr_idx_d = clr_idx_q;
    phase_d   = phase_q;
    report_d  = report_q;
    count_d   = count_q;
    done_d    = 1'b0;
    joined_d  = 1'b0;
    out_a_d   = out_a_q;
    out_b_d   = out_b_q;
    out_w_d   = out_w_q;
    out_cnt_d = out_cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = root_q;
    ram_raddr = cur_q;

    case (state_q)
      // Rewrite every entry to point at itself
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_last && report_q) begin
          report_d  = 1'b0;
          done_d    = 1'b1;
          out_a_d   = a_q;
          out_b_d   = b_q;
          out_w_d   = w_q;
          out_cnt_d = '0;
        end
      end

      // Capture a transaction: start the first lookup, begin a restart, or reject an out-of-range edge
      ST_IDLE: begin
        if (accept) begin
          a_d = node_a_i;
          b_d = node_b_i;
          w_d = edge_weight_i;
          if (op_i == OP_RESTART) begin
            clr_idx_d = '0;
            report_d  = 1'b1;
            count_d   = '0;
          end else if (in_rng) begin
            cur_d     = va_in;
            ram_raddr = va_in;
            phase_d   = 1'b0;
          end else begin
            done_d    = 1'b1;
            out_a_d   = node_a_i;
            out_b_d   = node_b_i;
            out_w_d   = edge_weight_i;
            out_cnt_d = count_q;
          end
        end
      end

      // Follow parent pointers up to the root
      ST_FIND: begin
        if (root_hit) begin
          root_d = cur_q;
          if (start_v != cur_q) begin
            cur_d     = start_v;
            ram_raddr = start_v;
          end else if (!phase_q) begin
            ra_d      = cur_q;
            phase_d   = 1'b1;
            cur_d     = vb;
            ram_raddr = vb;
          end else begin
            rb_d = cur_q;
          end
        end else begin
          cur_d     = ram_rdata;
          ram_raddr = ram_rdata;
        end
      end

      // Second walk: point each vertex on the path straight at the root
      ST_COMP: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = root_q;
        if (comp_end) begin
          if (!phase_q) begin
            ra_d      = root_q;
            phase_d   = 1'b1;
            cur_d     = vb;
            ram_raddr = vb;
          end else begin
            rb_d = root_q;
          end
        end else begin
          cur_d     = ram_rdata;
          ram_raddr = ram_rdata;
        end
      end

      // Link the first root under the second and report
      ST_LINK: begin
        done_d  = 1'b1;
        out_a_d = a_q;
        out_b_d = b_q;
        out_w_d = w_q;
        if (ra_q != rb_q) begin
          ram_we    = 1'b1;
          ram_waddr = ra_q;
          ram_wdata = rb_q;
          count_d   = count_q + 1'b1;
          joined_d  = 1'b1;
        end
        out_cnt_d = count_d;
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      report_q  <= 1'b0;
      count_q   <= '0;
      phase_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      report_q  <= report_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      done_q    <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    w_q       <= w_d;
    cur_q     <= cur_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    rb_q      <= rb_d;
    joined_q  <= joined_d;
    out_a_q   <= out_a_d;
    out_b_q   <= out_b_d;
    out_w_q   <= out_w_d;
    out_cnt_q <= out_cnt_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign joined_o     = joined_q;
  assign out_node_a_o = out_a_q;
  assign out_node_b_o = out_b_q;
  assign out_weight_o = out_w_q;
  assign tree_edges_o = out_cnt_q;

endmodule

`default_nettype wire

### dv/tb_kruskal_union_find_engine.sv
`timescale 1ns / 1ps

module tb_kruskal_union_find_engine;

  import kufe_pkg::*;

  localparam int  CYCLE_LIMIT     = 4_000_000;
  localparam int  RAND_PHASES     = 4;
  localparam int  ITEMS_PER_PHASE = 400;
  localparam int  QUIET_TAIL      = 200;
  localparam int  DRAIN_CYCLES    = 100;
  localparam int  NUM_DIRECTED    = 18;

  // One decision as it should leave the engine
  typedef struct packed {
    logic              joined;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WGT_W-1:0]  weight;
    logic [CNT_W-1:0]  tree_edges;
  } edge_decision_t;

  // Directed stimulus row; typed rows carry their own joined / count
  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WGT_W-1:0]  weight;
    logic              typed;
    logic              joined;
    logic [CNT_W-1:0]  tree_edges;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              op_i;
  logic [NODE_W-1:0] node_a_i;
  logic [NODE_W-1:0] node_b_i;
  logic [WGT_W-1:0]  edge_weight_i;
  logic              done_o;
  logic              joined_o;
  logic [NODE_W-1:0] out_node_a_o;
  logic [NODE_W-1:0] out_node_b_o;
  logic [WGT_W-1:0]  out_weight_o;
  logic [CNT_W-1:0]  tree_edges_o;

  // Shadow disjoint-set forest and tree-edge count
  logic [NODE_W-1:0] forest_parent [NUM_VERTICES];
  logic [CNT_W-1:0]  forest_tree_cnt;

  edge_decision_t    pending_decisions [$];
  stim_row_t         directed_rows [NUM_DIRECTED];
  int unsigned       mismatch_cnt;
  int unsigned       cycle_cnt;

  kruskal_union_find_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_weight_i (edge_weight_i),
    .done_o        (done_o),
    .joined_o      (joined_o),
    .out_node_a_o  (out_node_a_o),
    .out_node_b_o  (out_node_b_o),
    .out_weight_o  (out_weight_o),
    .tree_edges_o  (tree_edges_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Every vertex its own set, count cleared
  function automatic void clear_forest();
    for (int i = 0; i < NUM_VERTICES; i++) begin
      forest_parent[i] = NODE_W'(i);
    end
    forest_tree_cnt = '0;
  endfunction

  // Root walk, then point every vertex on the walk straight at the root
  function automatic logic [NODE_W-1:0] find_and_compress(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    int                steps;
    root  = v;
    steps = 0;
    while (forest_parent[root] != root && steps < NUM_VERTICES) begin
      root = forest_parent[root];
      steps++;
    end
    cur   = v;
    steps = 0;
    while (cur != root && steps < NUM_VERTICES) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      steps++;
    end
    return root;
  endfunction

  // Apply one accepted transaction to the shadow forest
  function automatic edge_decision_t decide_edge(input logic op, input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
    edge_decision_t    d;
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    d.joined = 1'b0;
    if (op == OP_RESTART) begin
      clear_forest();
    end else if (int'(a) < NUM_VERTICES && int'(b) < NUM_VERTICES) begin
      root_a = find_and_compress(a);
      root_b = find_and_compress(b);
      if (root_a != root_b) begin
        forest_parent[root_a] = root_b;
        forest_tree_cnt       = forest_tree_cnt + 1'b1;
        d.joined              = 1'b1;
      end
    end
    d.node_a     = a;
    d.node_b     = b;
    d.weight     = w;
    d.tree_edges = forest_tree_cnt;
    return d;
  endfunction

  // Present a command at the falling edge and hold it until accepted
  task automatic send_command(input logic op, input logic [NODE_W-1:0] a,
                              input logic [NODE_W-1:0] b, input logic [WGT_W-1:0] w,
                              input logic typed, input logic exp_joined,
                              input logic [CNT_W-1:0] exp_cnt);
    edge_decision_t d;
    @(negedge clk_i);
    start         <= 1'b1;
    op_i          <= op;
    node_a_i      <= a;
    node_b_i      <= b;
    edge_weight_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    d = decide_edge(op, a, b, w);
    if (typed) begin
      d.joined     = exp_joined;
      d.tree_edges = exp_cnt;
    end
    pending_decisions.push_back(d);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: strobe is single-cycle, the receiver cannot stall
  always @(posedge clk_i) begin
    edge_decision_t e;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        e = pending_decisions.pop_front();
        if (joined_o !== e.joined)
          report_mismatch($sformatf("joined got %0h exp %0h", joined_o, e.joined));
        if (out_node_a_o !== e.node_a)
          report_mismatch($sformatf("out_node_a got %0h exp %0h", out_node_a_o, e.node_a));
        if (out_node_b_o !== e.node_b)
          report_mismatch($sformatf("out_node_b got %0h exp %0h", out_node_b_o, e.node_b));
        if (out_weight_o !== e.weight)
          report_mismatch($sformatf("out_weight got %0h exp %0h", out_weight_o, e.weight));
        if (tree_edges_o !== e.tree_edges)
          report_mismatch($sformatf("tree_edges got %0h exp %0h", tree_edges_o, e.tree_edges));
      end
    end
  end

  initial begin
    int                pool_size;
    int                idle_pct;
    int                roll;
    int                wgt;
    int                sent;
    logic [NODE_W-1:0] pool_base;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] prev_b;

    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    start         = 1'b0;
    op_i          = OP_EDGE;
    node_a_i      = '0;
    node_b_i      = '0;
    edge_weight_i = '0;
    rst_ni        = 1'b0;
    clear_forest();

    // Extremes, self-loops, a chain walked deep and restarts
    directed_rows = '{
      '{OP_EDGE,    16'h0000, 16'hFFFF, 8'h00, 1'b1, 1'b1, 16'd1},
      '{OP_EDGE,    16'hFFFF, 16'h0000, 8'hFF, 1'b1, 1'b0, 16'd1},
      '{OP_EDGE,    16'h0007, 16'h0007, 8'h80, 1'b1, 1'b0, 16'd1},
      '{OP_EDGE,    16'h0001, 16'h0002, 8'h01, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0002, 16'h0003, 8'h02, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0003, 16'h0004, 8'h03, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0004, 16'h0005, 8'h04, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0005, 16'h0006, 8'h05, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0001, 16'h0064, 8'h06, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0006, 16'h0001, 8'h07, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0000, 16'h0006, 8'h08, 1'b0, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0064, 16'hFFFF, 8'h09, 1'b0, 1'b0, 16'd0},
      '{OP_RESTART, 16'hAAAA, 16'h5555, 8'hA5, 1'b1, 1'b0, 16'd0},
      '{OP_EDGE,    16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 16'd0},
      '{OP_EDGE,    16'h5555, 16'hAAAA, 8'h5A, 1'b1, 1'b1, 16'd1},
      '{OP_RESTART, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 16'd0},
      '{OP_EDGE,    16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, 16'd0},
      '{OP_EDGE,    16'h5555, 16'h0000, 8'h3C, 1'b1, 1'b1, 16'd1}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].op, directed_rows[i].node_a, directed_rows[i].node_b,
                   directed_rows[i].weight, directed_rows[i].typed,
                   directed_rows[i].joined, directed_rows[i].tree_edges);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 6));
    end

    // Random phases: each opens with a restart once the engine has drained
    sent = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: pool_size = 8;
        1: pool_size = 32;
        2: pool_size = 128;
        default: pool_size = 1024;
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      pool_base = NODE_W'($urandom_range(0, 65535));
      wgt       = $urandom_range(0, 15);
      prev_b    = pool_base;
      drain_results();
      send_command(OP_RESTART, NODE_W'($urandom_range(0, 65535)),
                   NODE_W'($urandom_range(0, 65535)), WGT_W'($urandom_range(0, 255)),
                   1'b0, 1'b0, '0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: anywhere in the vertex space
          a = NODE_W'($urandom_range(0, 65535));
          b = NODE_W'($urandom_range(0, 65535));
        end else if (roll < 13) begin
          // self-loop
          a = pool_base + NODE_W'($urandom_range(0, pool_size - 1));
          b = a;
        end else if (roll < 25) begin
          // extend a chain so the walks get deep
          a = prev_b;
          b = pool_base + NODE_W'($urandom_range(0, pool_size - 1));
        end else begin
          a = pool_base + NODE_W'($urandom_range(0, pool_size - 1));
          b = pool_base + NODE_W'($urandom_range(0, pool_size - 1));
        end
        // weights mostly nondecreasing, with the odd jump
        if ($urandom_range(0, 99) < 3) wgt = $urandom_range(0, 255);
        else wgt = wgt + $urandom_range(0, 2);
        if (wgt > 255) wgt = 255;
        prev_b = b;
        send_command(OP_EDGE, a, b, WGT_W'(wgt), 1'b0, 1'b0, '0);
        sent++;
        if (sent < RAND_PHASES * ITEMS_PER_PHASE - QUIET_TAIL &&
            $urandom_range(0, 99) < idle_pct) begin
          idle_cycles($urandom_range(1, 6));
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
